### hw/rtl/dtr_pkg.sv
// shared types, codes and constants of the divider timer with reload
`default_nettype none

package dtr_pkg;

    // cycle bits of a tick that the divider takes in
    localparam int TICK_CYCLE_BITS = 8;
    localparam logic [7:0] CYCLE_MASK = 8'((1 << TICK_CYCLE_BITS) - 1);

    // one tick input of at most 255 crosses at most 32 boundaries of 8
    localparam int CROSS_W = 6;

    // configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [15:0] DIV_RESET_VALUE = 16'h0000;

    // operation codes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // bus register codes
    localparam logic [2:0] REG_DIV    = 3'd0;
    localparam logic [2:0] REG_TIMER  = 3'd1;
    localparam logic [2:0] REG_RELOAD = 3'd2;
    localparam logic [2:0] REG_CTRL   = 3'd3;

    localparam logic [2:0] CTRL_MASK   = 3'h7;
    localparam logic [7:0] TIMER_MAX   = 8'hFF;

    // input request, operation in the lowest bits
    typedef struct packed {
        logic [7:0] cycles;
        logic [7:0] write_data;
        logic [2:0] reg_select;
        logic [1:0] operation;
    } dtr_item_t;

    // result, read_data in the lowest bits
    typedef struct packed {
        logic       timer_irq;
        logic [7:0] read_data;
    } dtr_result_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic emit;
    } dtr_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic count_zero;
    } dtr_status_t;

    // log2 of the counter period selected by the low control bits
    function automatic logic [3:0] period_shift(input logic [1:0] sel);
        logic [3:0] sh;
        unique case (sel)
            2'd0: sh = 4'd3;
            2'd1: sh = 4'd4;
            2'd2: sh = 4'd6;
            2'd3: sh = 4'd8;
            default: sh = 4'd3;
        endcase
        return sh;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/divider_timer_with_reload.sv
// Divider timer with reload: top level with the configuration register.
//
// Requests come in on s_tvalid/s_tready/s_tdata: a tick of some cycles, a
// register read or a register write. Every request gives one result on
// m_tvalid/m_tready/m_tdata: the read byte and the overflow interrupt flag.
// A request is taken only while no earlier request is still being worked.
// Reads, writes and ticks with the counter disabled take no counter steps;
// an enabled tick takes N steps, where N (0 to 32) is the number of counter
// periods crossed, and the counter steps once a cycle through its increment
// and reload logic. Once all steps are done the controller moves the
// result into an output register, so the next request is taken while the
// result waits; if the receiver still stalls when the next result is done,
// the controller holds it until the register frees.
// Reset clears the divider to its reset value of zero, the counter, reload
// and control registers, and any pending result. The APB port holds the
// divider_reset_value register at addresses 0 to 3; reset also returns it to zero.
`default_nettype none

module divider_timer_with_reload (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // operation[1:0], reg_select[4:2], write_data[12:5], cycles[20:13]
    input  wire logic [23:0]                    s_tdata,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // read_data[7:0], timer_irq[8]
    output logic [15:0]                         m_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [dtr_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [dtr_pkg::PDATA_W-1:0]    pwdata,
    output logic [dtr_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready
);
    import dtr_pkg::*;

    logic [15:0] div_reset_reg;
    dtr_item_t   item;
    dtr_cmd_t    cmd;
    dtr_status_t status;
    dtr_result_t result;
    logic        cfg_write;

    // configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_reset_reg <= 16'h0000;
        else if (cfg_write)
            div_reset_reg <= pwdata[15:0];
    end

    assign prdata = (paddr[2] == 1'b0) ? {16'd0, div_reset_reg} : '0;

    // stream payloads
    assign item    = dtr_item_t'(s_tdata[20:0]);
    assign m_tdata = {7'd0, result};

    dtr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    dtr_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .status (status),
        .result (result)
    );

endmodule

`default_nettype wire

### hw/rtl/dtr_ctrl.sv
// controller: accepts a request, runs the counter steps, hands over the result
`default_nettype none

module dtr_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output dtr_pkg::dtr_cmd_t         cmd,
    input  wire dtr_pkg::dtr_status_t status
);
    import dtr_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t state_reg;
    logic   m_tvalid_reg;
    logic   out_free;

    // output register can take a new result
    assign out_free = !m_tvalid_reg || m_tready;

    // commands to the datapath
    always_comb
    begin
        cmd.load = (state_reg == ST_IDLE) && s_tvalid;
        cmd.step = (state_reg == ST_RUN) && !status.count_zero;
        cmd.emit = (state_reg == ST_RUN) && status.count_zero && out_free;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    // state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                        state_reg <= ST_RUN;
                end
                ST_RUN:
                begin
                    if (cmd.emit)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase

            if (cmd.emit)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/dtr_datapath.sv
// datapath: divider, counter, reload and control registers, result register
`default_nettype none

module dtr_datapath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire dtr_pkg::dtr_item_t  item,
    input  wire dtr_pkg::dtr_cmd_t   cmd,
    output dtr_pkg::dtr_status_t     status,
    output dtr_pkg::dtr_result_t     result
);
    import dtr_pkg::*;

    logic [15:0]        div_reg, div_next;
    logic [7:0]         timer_reg, timer_next;
    logic [7:0]         reload_reg, reload_next;
    logic [2:0]         ctrl_reg, ctrl_next;
    logic [CROSS_W-1:0] cross_reg, cross_next;
    logic               irq_reg, irq_next;
    logic [7:0]         res_data_reg, res_data_next;
    dtr_result_t        out_reg, out_next;

    logic [7:0]         cyc;
    logic [16:0]        sum;
    logic [3:0]         sh;
    logic [16:0]        cross_full;
    logic [7:0]         rd_value;

    // boundaries crossed by this tick
    always_comb
    begin
        cyc        = item.cycles & CYCLE_MASK;
        sum        = {1'b0, div_reg} + {9'd0, cyc};
        sh         = period_shift(ctrl_reg[1:0]);
        cross_full = (sum >> sh) - ({1'b0, div_reg} >> sh);
    end

    // bus read mux
    always_comb
    begin
        unique case (item.reg_select)
            REG_DIV:    rd_value = div_reg[15:8];
            REG_TIMER:  rd_value = timer_reg;
            REG_RELOAD: rd_value = reload_reg;
            REG_CTRL:   rd_value = {5'd0, ctrl_reg & CTRL_MASK};
            default:    rd_value = 8'd0;
        endcase
    end

    // next values
    always_comb
    begin
        div_next      = div_reg;
        timer_next    = timer_reg;
        reload_next   = reload_reg;
        ctrl_next     = ctrl_reg;
        cross_next    = cross_reg;
        irq_next      = irq_reg;
        res_data_next = res_data_reg;
        out_next      = out_reg;

        // start of a request
        if (cmd.load)
        begin
            res_data_next = 8'd0;
            irq_next      = 1'b0;
            cross_next    = '0;
            unique case (item.operation)
                OP_TICK:
                begin
                    div_next = sum[15:0];
                    if (ctrl_reg[2])
                        cross_next = cross_full[CROSS_W-1:0];
                end
                OP_READ:
                    res_data_next = rd_value;
                OP_WRITE:
                begin
                    unique case (item.reg_select)
                        REG_DIV:    div_next    = 16'h0000;
                        REG_TIMER:  timer_next  = item.write_data;
                        REG_RELOAD: reload_next = item.write_data;
                        REG_CTRL:   ctrl_next   = item.write_data[2:0] & CTRL_MASK;
                        default:    ;
                    endcase
                end
                default: ;
            endcase
        end

        // one counter increment, reload on overflow
        if (cmd.step)
        begin
            cross_next = cross_reg - CROSS_W'(1);
            if (timer_reg == TIMER_MAX)
            begin
                timer_next = reload_reg;
                irq_next   = 1'b1;
            end
            else
                timer_next = timer_reg + 8'd1;
        end

        // result into the output register
        if (cmd.emit)
        begin
            out_next.read_data = res_data_reg;
            out_next.timer_irq = irq_reg;
        end
    end

    // architectural and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_reg    <= DIV_RESET_VALUE;
            timer_reg  <= 8'd0;
            reload_reg <= 8'd0;
            ctrl_reg   <= 3'd0;
            cross_reg  <= '0;
            irq_reg    <= 1'b0;
        end
        else
        begin
            div_reg    <= div_next;
            timer_reg  <= timer_next;
            reload_reg <= reload_next;
            ctrl_reg   <= ctrl_next;
            cross_reg  <= cross_next;
            irq_reg    <= irq_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        res_data_reg <= res_data_next;
        out_reg      <= out_next;
    end

    assign status.count_zero = (cross_reg == '0);
    assign result            = out_reg;

endmodule

`default_nettype wire

### hw/rtl/dtr_checker.sv
// port-level checks of the divider timer with reload, bound to the top level
`default_nettype none

module dtr_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        m_tvalid,
    input wire logic        m_tready
);
    logic [1:0] pend_reg;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    // requests taken but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= 2'd0;
        else if (in_acc && !out_acc)
            pend_reg <= pend_reg + 2'd1;
        else if (out_acc && !in_acc)
            pend_reg <= pend_reg - 2'd1;
    end

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one request in work, one result waiting at most
    a_pend_max: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("too many requests outstanding");

    // no result without a request behind it
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> pend_reg != 2'd0)
        else $error("result without request");

    // a request is worked before the next is taken
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !s_tready)
        else $error("request taken back to back");

    // interrupt flag never with nonzero read data, upper result bits zero
    a_irq_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[8] && (m_tdata[7:0] != 8'd0)) && (m_tdata[15:9] == 7'd0))
        else $error("interrupt and read data together");

endmodule

bind divider_timer_with_reload dtr_checker u_dtr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire
